// File: design/index_triple_set_matcher_macros.svh
// assertion macros for the index triple set matcher checker
`ifndef INDEX_TRIPLE_SET_MATCHER_MACROS_SVH
`define INDEX_TRIPLE_SET_MATCHER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define ITSM_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itsm check failed");

// next-cycle implication, sampled on clk, off during reset
`define ITSM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itsm check failed");

`endif

// File: design/itsm_pkg.sv
// shared types and constants of the index triple set matcher
package itsm_pkg;

    localparam int OP_BITS       = 2;
    localparam int KEY_IN_BITS   = 10;
    localparam int ENTRY_IN_BITS = 10;
    localparam int PNUM_BITS     = 16;
    localparam int COUNT_BITS    = 16;
    localparam int HASH_BITS     = 64;
    localparam int HALF_BITS     = 32;
    localparam int MOD_CHUNK     = 8;
    localparam int FOLD_SHIFT_A  = 17;
    localparam int FOLD_SHIFT_B  = 31;
    localparam int FOLD_SHIFT_C  = 47;
    localparam int MIX_SHIFT     = 29;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [HASH_BITS-1:0]  HASH_MUL  = 64'h9E37_79B9_7F4A_7C15;

    typedef enum logic [OP_BITS-1:0] {
        OP_CLEAR  = 2'd0,
        OP_INSERT = 2'd1,
        OP_PROBE  = 2'd2,
        OP_QUERY  = 2'd3
    } itsm_op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_DUP  = 2'd1,
        ST_FULL = 2'd2,
        ST_MISS = 2'd3
    } itsm_status_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_MUL,
        F_MIX,
        F_MOD,
        F_PUSH
    } itsm_front_state_t;

    typedef enum logic [2:0] {
        B_INIT,
        B_IDLE,
        B_SLOT,
        B_COUNT,
        B_QUERY
    } itsm_back_state_t;

    typedef struct packed {
        itsm_status_t             status;
        logic                     found;
        logic [ENTRY_IN_BITS-1:0] set_entry;
        logic [PNUM_BITS-1:0]     probe_number;
        logic [COUNT_BITS-1:0]    match_count;
        logic                     any_unmatched;
    } itsm_result_t;

endpackage

// File: design/itsm_item_if.sv
// input item channel of the index triple set matcher
interface itsm_item_if import itsm_pkg::*; ();
    logic                            valid;
    logic                            ready;
    logic [OP_BITS-1:0]              op;
    logic signed [KEY_IN_BITS-1:0]   key_h;
    logic signed [KEY_IN_BITS-1:0]   key_k;
    logic signed [KEY_IN_BITS-1:0]   key_l;
    logic [ENTRY_IN_BITS-1:0]        entry_number;

    modport source (output valid, op, key_h, key_k, key_l, entry_number, input ready);
    modport sink   (input valid, op, key_h, key_k, key_l, entry_number, output ready);
endinterface

// File: design/itsm_result_if.sv
// result item channel of the index triple set matcher
interface itsm_result_if import itsm_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic                     found;
    logic [ENTRY_IN_BITS-1:0] set_entry;
    logic [PNUM_BITS-1:0]     probe_number;
    logic [COUNT_BITS-1:0]    match_count;
    logic                     any_unmatched;

    modport source (output valid, status, found, set_entry, probe_number, match_count,
                    any_unmatched, input ready);
    modport sink   (input valid, status, found, set_entry, probe_number, match_count,
                    any_unmatched, output ready);
endinterface

// File: design/itsm_queue.sv
// two-entry command queue between front and back
module itsm_queue import itsm_pkg::*; #(
    parameter int DATA_BITS = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  logic [DATA_BITS-1:0] push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output logic [DATA_BITS-1:0] pop_data
);

    logic [DATA_BITS-1:0] data_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;
    logic                 do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_data   = data_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// File: design/itsm_front.sv
// front end: takes items, builds the key and hashes insert and probe keys to a home slot
module itsm_front import itsm_pkg::*; #(
    parameter int TABLE_ENTRIES  = 1024,
    parameter int COMPONENT_BITS = 10,
    parameter int SLOT_BITS      = 10,
    parameter int KEY_BITS       = 30,
    parameter int CMD_BITS       = 62
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                init_busy,
    itsm_item_if.sink           item,
    output logic                push_valid,
    input  logic                push_ready,
    output logic [CMD_BITS-1:0] push_data
);

    localparam bit IS_POW2   = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
    localparam int REM_BITS  = SLOT_BITS + 1;
    localparam int MOD_STEPS = HASH_BITS / MOD_CHUNK;
    localparam int MCNT_BITS = $clog2(MOD_STEPS);
    localparam logic [REM_BITS-1:0]  MOD_VALUE = REM_BITS'(TABLE_ENTRIES);
    localparam logic [MCNT_BITS-1:0] MCNT_LAST = MCNT_BITS'(MOD_STEPS - 1);

    itsm_front_state_t        state_reg, state_next;
    itsm_op_t                 op_reg, op_next;
    logic [KEY_BITS-1:0]      key_reg, key_next;
    logic [ENTRY_IN_BITS-1:0] qentry_reg, qentry_next;
    logic [HASH_BITS-1:0]     fold_reg, fold_next;
    logic [HASH_BITS-1:0]     prod_reg, prod_next;
    logic [HASH_BITS-1:0]     acc_reg, acc_next;
    logic [HASH_BITS-1:0]     hv_reg, hv_next;
    logic [REM_BITS-1:0]      rem_reg, rem_next;
    logic [1:0]               step_reg, step_next;
    logic [MCNT_BITS-1:0]     mcnt_reg, mcnt_next;

    logic                     accept;
    logic [KEY_BITS-1:0]      key_in;
    logic [HASH_BITS-1:0]     key_wide;
    logic [HALF_BITS-1:0]     mul_a, mul_b;
    logic [SLOT_BITS-1:0]     home;
    logic signed [COMPONENT_BITS-1:0] comp_h, comp_k, comp_l;

    assign comp_h   = COMPONENT_BITS'(item.key_h);
    assign comp_k   = COMPONENT_BITS'(item.key_k);
    assign comp_l   = COMPONENT_BITS'(item.key_l);
    assign key_in   = {comp_l, comp_k, comp_h};
    assign key_wide = HASH_BITS'(key_in);

    assign item.ready = (state_reg == F_IDLE) && !init_busy;
    assign accept     = item.valid && item.ready;
    assign home       = IS_POW2 ? hv_reg[SLOT_BITS-1:0] : rem_reg[SLOT_BITS-1:0];
    assign push_valid = (state_reg == F_PUSH);
    assign push_data  = {op_reg, key_reg, qentry_reg, home};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    if (item.op inside {OP_CLEAR, OP_QUERY})
                        state_next = F_PUSH;
                    else
                        state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                if (step_reg == 2'd3)
                    state_next = F_MIX;
            end
            F_MIX:
            begin
                state_next = IS_POW2 ? F_PUSH : F_MOD;
            end
            F_MOD:
            begin
                if (mcnt_reg == MCNT_LAST)
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (push_ready)
                    state_next = F_IDLE;
            end
            default: state_next = F_IDLE;
        endcase
    end

    always_comb
    begin
        logic [REM_BITS-1:0] r;
        logic [REM_BITS-1:0] t;
        op_next     = op_reg;
        key_next    = key_reg;
        qentry_next = qentry_reg;
        fold_next   = fold_reg;
        prod_next   = prod_reg;
        acc_next    = acc_reg;
        hv_next     = hv_reg;
        rem_next    = rem_reg;
        step_next   = step_reg;
        mcnt_next   = mcnt_reg;
        mul_a       = '0;
        mul_b       = '0;
        r           = rem_reg;
        t           = rem_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (accept)
                begin
                    op_next     = itsm_op_t'(item.op);
                    key_next    = key_in;
                    qentry_next = item.entry_number;
                    fold_next   = key_wide ^ (key_wide >> FOLD_SHIFT_A)
                                ^ (key_wide >> FOLD_SHIFT_B) ^ (key_wide >> FOLD_SHIFT_C);
                    step_next   = 2'd0;
                end
            end
            F_MUL:
            begin
                case (step_reg)
                    2'd0:
                    begin
                        mul_a = fold_reg[HALF_BITS-1:0];
                        mul_b = HASH_MUL[HALF_BITS-1:0];
                    end
                    2'd1:
                    begin
                        mul_a = fold_reg[HALF_BITS-1:0];
                        mul_b = HASH_MUL[HASH_BITS-1:HALF_BITS];
                    end
                    2'd2:
                    begin
                        mul_a = fold_reg[HASH_BITS-1:HALF_BITS];
                        mul_b = HASH_MUL[HALF_BITS-1:0];
                    end
                    default:
                    begin
                        mul_a = '0;
                        mul_b = '0;
                    end
                endcase
                prod_next = HASH_BITS'(mul_a) * HASH_BITS'(mul_b);
                case (step_reg)
                    2'd0:    acc_next = acc_reg;
                    2'd1:    acc_next = prod_reg;
                    default: acc_next = {acc_reg[HASH_BITS-1:HALF_BITS] + prod_reg[HALF_BITS-1:0],
                                         acc_reg[HALF_BITS-1:0]};
                endcase
                step_next = step_reg + 2'd1;
            end
            F_MIX:
            begin
                hv_next   = acc_reg ^ (acc_reg >> MIX_SHIFT);
                rem_next  = '0;
                mcnt_next = '0;
            end
            F_MOD:
            begin
                for (int j = 0; j < MOD_CHUNK; j++)
                begin
                    t = {r[SLOT_BITS-1:0], hv_reg[HASH_BITS-1-j]};
                    if (t >= MOD_VALUE)
                        t = t - MOD_VALUE;
                    r = t;
                end
                rem_next  = r;
                hv_next   = hv_reg << MOD_CHUNK;
                mcnt_next = mcnt_reg + MCNT_BITS'(1);
            end
            F_PUSH:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            step_reg  <= 2'd0;
            mcnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            mcnt_reg  <= mcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        key_reg    <= key_next;
        qentry_reg <= qentry_next;
        fold_reg   <= fold_next;
        prod_reg   <= prod_next;
        acc_reg    <= acc_next;
        hv_reg     <= hv_next;
        rem_reg    <= rem_next;
    end

endmodule

// File: design/itsm_back.sv
// back end: probes the slot table, keeps match counts and drives results
module itsm_back import itsm_pkg::*; #(
    parameter int TABLE_ENTRIES = 1024,
    parameter int SLOT_BITS     = 10,
    parameter int KEY_BITS      = 30,
    parameter int CMD_BITS      = 62
) (
    input  logic                clk,
    input  logic                rst_n,
    output logic                init_busy,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  logic [CMD_BITS-1:0] pop_data,
    itsm_result_if.source       result
);

    localparam int SLOT_WORD   = 1 + SLOT_BITS + KEY_BITS;
    localparam int HOME_LO     = 0;
    localparam int QENTRY_LO   = SLOT_BITS;
    localparam int KEY_LO      = QENTRY_LO + ENTRY_IN_BITS;
    localparam int OP_LO       = KEY_LO + KEY_BITS;
    localparam int CMP_BITS    = SLOT_BITS + ENTRY_IN_BITS + 1;
    localparam logic [SLOT_BITS-1:0] SLOT_LAST = SLOT_BITS'(TABLE_ENTRIES - 1);
    localparam logic [SLOT_BITS:0]   SIZE_FULL = (SLOT_BITS + 1)'(TABLE_ENTRIES);

    logic [SLOT_WORD-1:0]  slot_mem [TABLE_ENTRIES];
    logic [COUNT_BITS-1:0] count_mem [TABLE_ENTRIES];
    logic [SLOT_WORD-1:0]  slot_rdata_reg;
    logic [COUNT_BITS-1:0] count_rdata_reg;

    itsm_back_state_t         state_reg, state_next;
    logic [SLOT_BITS-1:0]     sweep_reg, sweep_next;
    logic                     emit_reg, emit_next;
    itsm_op_t                 op_reg, op_next;
    logic [KEY_BITS-1:0]      key_reg, key_next;
    logic [ENTRY_IN_BITS-1:0] qentry_reg, qentry_next;
    logic                     in_range_reg, in_range_next;
    logic [SLOT_BITS-1:0]     cur_reg, cur_next;
    logic [SLOT_BITS-1:0]     n_reg, n_next;
    logic [SLOT_BITS-1:0]     hit_entry_reg, hit_entry_next;
    logic [PNUM_BITS-1:0]     pnum_reg, pnum_next;
    logic [SLOT_BITS:0]       set_size_reg, set_size_next;
    logic [PNUM_BITS-1:0]     probe_cnt_reg, probe_cnt_next;
    logic [SLOT_BITS:0]       unmatched_reg, unmatched_next;
    logic                     missed_reg, missed_next;
    logic                     out_valid_reg, out_valid_next;
    itsm_result_t             result_reg, result_next;

    logic                     slot_we;
    logic [SLOT_BITS-1:0]     slot_waddr, slot_raddr;
    logic [SLOT_WORD-1:0]     slot_wdata;
    logic                     count_we;
    logic [SLOT_BITS-1:0]     count_waddr, count_raddr;
    logic [COUNT_BITS-1:0]    count_wdata;

    itsm_op_t                 pop_op;
    logic [KEY_BITS-1:0]      pop_key;
    logic [ENTRY_IN_BITS-1:0] pop_qentry;
    logic [SLOT_BITS-1:0]     pop_home;
    logic                     take;
    logic                     rd_valid;
    logic [SLOT_BITS-1:0]     rd_entry;
    logic [KEY_BITS-1:0]      rd_key;
    logic                     key_match;
    logic                     last_step;
    logic [SLOT_BITS-1:0]     next_slot;
    logic [COUNT_BITS-1:0]    bumped;

    assign pop_op     = itsm_op_t'(pop_data[OP_LO +: OP_BITS]);
    assign pop_key    = pop_data[KEY_LO +: KEY_BITS];
    assign pop_qentry = pop_data[QENTRY_LO +: ENTRY_IN_BITS];
    assign pop_home   = pop_data[HOME_LO +: SLOT_BITS];
    assign take       = (state_reg == B_IDLE) && pop_valid && !out_valid_reg;
    assign pop_ready  = take;
    assign init_busy  = (state_reg == B_INIT) && !emit_reg;

    assign rd_valid   = slot_rdata_reg[SLOT_WORD-1];
    assign rd_entry   = slot_rdata_reg[KEY_BITS +: SLOT_BITS];
    assign rd_key     = slot_rdata_reg[KEY_BITS-1:0];
    assign key_match  = rd_valid && (rd_key == key_reg);
    assign last_step  = (n_reg == SLOT_LAST);
    assign next_slot  = (cur_reg == SLOT_LAST) ? '0 : cur_reg + SLOT_BITS'(1);
    assign bumped     = (count_rdata_reg == COUNT_MAX) ? count_rdata_reg
                                                       : count_rdata_reg + COUNT_BITS'(1);

    assign result.valid         = out_valid_reg;
    assign result.status        = result_reg.status;
    assign result.found         = result_reg.found;
    assign result.set_entry     = result_reg.set_entry;
    assign result.probe_number  = result_reg.probe_number;
    assign result.match_count   = result_reg.match_count;
    assign result.any_unmatched = result_reg.any_unmatched;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_INIT:
            begin
                if (sweep_reg == SLOT_LAST)
                    state_next = B_IDLE;
            end
            B_IDLE:
            begin
                if (take)
                begin
                    unique case (pop_op) inside
                        OP_CLEAR:            state_next = B_INIT;
                        OP_INSERT, OP_PROBE: state_next = B_SLOT;
                        OP_QUERY:            state_next = B_QUERY;
                        default:             state_next = B_IDLE;
                    endcase
                end
            end
            B_SLOT:
            begin
                if (!rd_valid)
                    state_next = B_IDLE;
                else if (key_match)
                    state_next = (op_reg == OP_INSERT) ? B_IDLE : B_COUNT;
                else if (last_step)
                    state_next = B_IDLE;
            end
            B_COUNT: state_next = B_IDLE;
            B_QUERY: state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
    end

    always_comb
    begin
        sweep_next     = sweep_reg;
        emit_next      = emit_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        qentry_next    = qentry_reg;
        in_range_next  = in_range_reg;
        cur_next       = cur_reg;
        n_next         = n_reg;
        hit_entry_next = hit_entry_reg;
        pnum_next      = pnum_reg;
        set_size_next  = set_size_reg;
        probe_cnt_next = probe_cnt_reg;
        unmatched_next = unmatched_reg;
        missed_next    = missed_reg;
        out_valid_next = out_valid_reg && !result.ready;
        result_next    = result_reg;
        slot_we        = 1'b0;
        slot_waddr     = cur_reg;
        slot_wdata     = '0;
        slot_raddr     = cur_reg;
        count_we       = 1'b0;
        count_waddr    = hit_entry_reg;
        count_wdata    = '0;
        count_raddr    = hit_entry_reg;
        unique case (state_reg)
            B_INIT:
            begin
                slot_we    = 1'b1;
                slot_waddr = sweep_reg;
                slot_wdata = '0;
                sweep_next = sweep_reg + SLOT_BITS'(1);
                if (sweep_reg == SLOT_LAST)
                begin
                    sweep_next = '0;
                    if (emit_reg)
                    begin
                        out_valid_next = 1'b1;
                        result_next    = '0;
                    end
                    emit_next = 1'b0;
                end
            end
            B_IDLE:
            begin
                if (take)
                begin
                    op_next     = pop_op;
                    key_next    = pop_key;
                    qentry_next = pop_qentry;
                    cur_next    = pop_home;
                    n_next      = '0;
                    slot_raddr  = pop_home;
                    count_raddr = SLOT_BITS'(pop_qentry);
                    in_range_next = CMP_BITS'(pop_qentry) < CMP_BITS'(set_size_reg);
                    pnum_next   = '0;
                    unique case (pop_op) inside
                        OP_CLEAR:
                        begin
                            sweep_next     = '0;
                            emit_next      = 1'b1;
                            set_size_next  = '0;
                            probe_cnt_next = '0;
                            unmatched_next = '0;
                            missed_next    = 1'b0;
                        end
                        OP_PROBE:
                        begin
                            pnum_next      = probe_cnt_reg;
                            probe_cnt_next = probe_cnt_reg + PNUM_BITS'(1);
                        end
                        OP_INSERT, OP_QUERY:
                        begin
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_SLOT:
            begin
                result_next = '0;
                result_next.probe_number = pnum_reg;
                if (key_match)
                begin
                    hit_entry_next = rd_entry;
                    count_raddr    = rd_entry;
                    if (op_reg == OP_INSERT)
                    begin
                        out_valid_next        = 1'b1;
                        result_next.status    = ST_DUP;
                        result_next.set_entry = ENTRY_IN_BITS'(rd_entry);
                    end
                end
                else if (!rd_valid || last_step)
                begin
                    out_valid_next = 1'b1;
                    if (op_reg == OP_INSERT)
                    begin
                        if (rd_valid || set_size_reg == SIZE_FULL)
                        begin
                            result_next.status = ST_FULL;
                        end
                        else
                        begin
                            slot_we     = 1'b1;
                            slot_waddr  = cur_reg;
                            slot_wdata  = {1'b1, SLOT_BITS'(set_size_reg), key_reg};
                            count_we    = 1'b1;
                            count_waddr = SLOT_BITS'(set_size_reg);
                            count_wdata = '0;
                            result_next.set_entry = ENTRY_IN_BITS'(set_size_reg);
                            set_size_next  = set_size_reg + (SLOT_BITS + 1)'(1);
                            unmatched_next = unmatched_reg + (SLOT_BITS + 1)'(1);
                        end
                    end
                    else
                    begin
                        result_next.status = ST_MISS;
                        missed_next        = 1'b1;
                    end
                end
                else
                begin
                    cur_next   = next_slot;
                    n_next     = n_reg + SLOT_BITS'(1);
                    slot_raddr = next_slot;
                end
                result_next.any_unmatched = (unmatched_next != '0) || missed_next;
            end
            B_COUNT:
            begin
                if (count_rdata_reg == '0 && unmatched_reg != '0)
                    unmatched_next = unmatched_reg - (SLOT_BITS + 1)'(1);
                count_we       = 1'b1;
                count_waddr    = hit_entry_reg;
                count_wdata    = bumped;
                out_valid_next = 1'b1;
                result_next.status        = ST_OK;
                result_next.found         = 1'b1;
                result_next.set_entry     = ENTRY_IN_BITS'(hit_entry_reg);
                result_next.probe_number  = pnum_reg;
                result_next.match_count   = bumped;
                result_next.any_unmatched = (unmatched_next != '0) || missed_reg;
            end
            B_QUERY:
            begin
                out_valid_next = 1'b1;
                result_next    = '0;
                result_next.set_entry     = qentry_reg;
                result_next.match_count   = in_range_reg ? count_rdata_reg : '0;
                result_next.any_unmatched = (unmatched_reg != '0) || missed_reg;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_INIT;
            sweep_reg     <= '0;
            emit_reg      <= 1'b0;
            set_size_reg  <= '0;
            probe_cnt_reg <= '0;
            unmatched_reg <= '0;
            missed_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            emit_reg      <= emit_next;
            set_size_reg  <= set_size_next;
            probe_cnt_reg <= probe_cnt_next;
            unmatched_reg <= unmatched_next;
            missed_reg    <= missed_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        qentry_reg    <= qentry_next;
        in_range_reg  <= in_range_next;
        cur_reg       <= cur_next;
        n_reg         <= n_next;
        hit_entry_reg <= hit_entry_next;
        pnum_reg      <= pnum_next;
        result_reg    <= result_next;
    end

    // slot table: valid, entry number, key
    always_ff @(posedge clk)
    begin
        if (slot_we)
            slot_mem[slot_waddr] <= slot_wdata;
        slot_rdata_reg <= slot_mem[slot_raddr];
    end

    // match counts by entry number
    always_ff @(posedge clk)
    begin
        if (count_we)
            count_mem[count_waddr] <= count_wdata;
        count_rdata_reg <= count_mem[count_raddr];
    end

endmodule

// File: design/index_triple_set_matcher.sv
// top level: keyed match table for signed index triples
// insert/probe: front folds, multiplies and mixes the key (and reduces the hash modulo
// TABLE_ENTRIES if that is not a power of two); back walks the slot chain from the home
// slot, then bumps the count on a probe hit; query reads a count; one item in flight in
// the back, two queued between the parts; after reset the back sweeps the slot table
// and takes no item meanwhile; a clear item runs the same sweep; its all-zero result follows
module index_triple_set_matcher import itsm_pkg::*; #(
    parameter int TABLE_ENTRIES  = 1024,
    parameter int COMPONENT_BITS = 10
) (
    input  logic          clk,
    input  logic          rst_n,
    itsm_item_if.sink     item,
    itsm_result_if.source result
);

    localparam int SLOT_BITS = $clog2(TABLE_ENTRIES);
    localparam int KEY_BITS  = 3 * COMPONENT_BITS;
    localparam int CMD_BITS  = OP_BITS + KEY_BITS + ENTRY_IN_BITS + SLOT_BITS;

    logic                init_busy;
    logic                push_valid, push_ready;
    logic [CMD_BITS-1:0] push_data;
    logic                pop_valid, pop_ready;
    logic [CMD_BITS-1:0] pop_data;

    itsm_front #(
        .TABLE_ENTRIES  (TABLE_ENTRIES),
        .COMPONENT_BITS (COMPONENT_BITS),
        .SLOT_BITS      (SLOT_BITS),
        .KEY_BITS       (KEY_BITS),
        .CMD_BITS       (CMD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .init_busy  (init_busy),
        .item       (item),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    itsm_queue #(
        .DATA_BITS (CMD_BITS)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    itsm_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .SLOT_BITS     (SLOT_BITS),
        .KEY_BITS      (KEY_BITS),
        .CMD_BITS      (CMD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .init_busy (init_busy),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .result    (result)
    );

endmodule

// File: design/itsm_checker.sv
// port-level checks of the index triple set matcher and their binding
`include "index_triple_set_matcher_macros.svh"

module itsm_checker import itsm_pkg::*; (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 result_valid,
    input logic                 result_ready,
    input logic [1:0]           status,
    input logic                 found,
    input logic [PNUM_BITS-1:0] probe_number,
    input logic                 any_unmatched
);

    `ITSM_ASSERT_NEXT(a_valid_holds, result_valid && !result_ready, result_valid)
    `ITSM_ASSERT_SAME(a_found_ok, result_valid && found, status == ST_OK)
    `ITSM_ASSERT_SAME(a_miss_flags, result_valid && status == ST_MISS, any_unmatched && !found)
    `ITSM_ASSERT_SAME(a_pnum_probe, result_valid && probe_number != '0, found || status == ST_MISS)

endmodule

bind index_triple_set_matcher itsm_checker u_itsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .result_valid  (result.valid),
    .result_ready  (result.ready),
    .status        (result.status),
    .found         (result.found),
    .probe_number  (result.probe_number),
    .any_unmatched (result.any_unmatched)
);
